// File: design/bpc_pkg.sv
// Package for the barometric pressure compensation core.
// Holds the compensation constants and the fixed-point helper functions.
// No dependencies.
`default_nettype none
package bpc_pkg;

  localparam int unsigned DIV_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [1:0] REG_OFFSET      = 2'd0;
  localparam logic [1:0] REG_TEMPERATURE = 2'd1;
  localparam logic [1:0] REG_CURVATURE   = 2'd2;
  localparam logic [1:0] REG_OVERSAMPLE  = 2'd3;

  localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
  localparam logic signed [31:0] P_SQ_COEF   = 32'sd3038;
  localparam logic signed [31:0] P_LIN_COEF  = -32'sd7357;
  localparam logic signed [31:0] P_OFFSET    = 32'sd3791;
  localparam logic signed [31:0] B4_BIAS     = 32'sd32768;
  localparam logic [31:0]        B7_SCALE    = 32'd50000;

  // Low 32 bits of a signed product; these bits equal the unsigned product too.
  function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] prod;
    prod = a * b;
    return prod[31:0];
  endfunction

  // Signed division by 2**k, truncating toward zero.
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                 input logic [4:0] k);
    logic signed [31:0] bias;
    bias = a[31] ? $signed((32'd1 << k) - 32'd1) : 32'sd0;
    return (a + bias) >>> k;
  endfunction

endpackage
`default_nettype wire

// File: design/bpc_div.sv
// Pipelined unsigned divider, one quotient bit per register stage.
// Carries a sideband word alongside each operand pair. Uses no package.
`default_nettype none
module bpc_div #(
  parameter int unsigned W      = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [W-1:0]      dividend,
  input  wire logic [W-1:0]      divisor,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [W-1:0]           quotient,
  output logic [SIDE_W-1:0]      side_out
);

  logic              vld  [W+1];
  logic [W-1:0]      num  [W+1];
  logic [W-1:0]      den  [W+1];
  logic [W-1:0]      rem  [W+1];
  logic [SIDE_W-1:0] side [W+1];

  assign vld[0]  = in_valid;
  assign num[0]  = dividend;
  assign den[0]  = divisor;
  assign rem[0]  = '0;
  assign side[0] = side_in;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0]   trial;
    logic         fits;
    logic [W-1:0] rem_next;
    always_comb begin
      trial    = {rem[i], num[i][W-1]};
      fits     = trial >= {1'b0, den[i]};
      rem_next = fits ? W'(trial - {1'b0, den[i]}) : trial[W-1:0];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        num[i+1]  <= {num[i][W-2:0], fits};
        den[i+1]  <= den[i];
        rem[i+1]  <= rem_next;
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[W];
  assign quotient  = num[W];
  assign side_out  = side[W];

endmodule
`default_nettype wire

// File: design/barometric_pressure_compensation_core.sv
// Barometric pressure compensation core: pipelined integer compensation sequence.
// Depends on bpc_pkg and on bpc_div for the two pipelined dividers.
//
// Usage: raw readings arrive on the s_axis channel, one transfer per item,
// tdata holding raw_temperature in bits 15:0 and raw_pressure in bits 34:16.
// The compensated pressure leaves on the m_axis channel, pressure_pa in tdata
// and divide_error in tuser. A zero divisor gives pressure 0 with the flag set.
// Calibration is written through the cfg channel (index 0 offset terms, 1
// temperature terms, 2 curvature terms, 3 oversampling mode); the user must write it only
// while the core is idle, which the core does not enforce; cfg_ready is always high.
// An item passes stages a-c, the first divider, stages d-j, the second divider and
// stages k, l, mm to the m_axis register; the two 32-stage restoring dividers are most of it.
// Throughput is one item per cycle. When the receiver stalls, the whole
// pipeline holds and s_axis_tready falls, so nothing is lost or repeated.
// Reset empties the pipeline and clears all calibration registers to zero.
`default_nettype none
module barometric_pressure_compensation_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [39:0]                    s_axis_tdata,  // raw_temperature, raw_pressure
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [bpc_pkg::DIV_W-1:0]           m_axis_tdata,  // pressure_pa
  output logic                                m_axis_tuser,  // divide_error
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned DIV_W = bpc_pkg::DIV_W;

  logic [63:0] cal_offset;
  logic [63:0] cal_temp;
  logic [31:0] cal_curve;
  logic [1:0]  oss;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset <= '0;
      cal_temp   <= '0;
      cal_curve  <= '0;
      oss        <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpc_pkg::REG_OFFSET:      cal_offset <= cfg_data;
        bpc_pkg::REG_TEMPERATURE: cal_temp   <= cfg_data;
        bpc_pkg::REG_CURVATURE:   cal_curve  <= cfg_data[31:0];
        bpc_pkg::REG_OVERSAMPLE:  oss        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
  assign ac1 = 32'($signed(cal_offset[15:0]));
  assign ac2 = 32'($signed(cal_offset[31:16]));
  assign ac3 = 32'($signed(cal_offset[47:32]));
  assign ac4 = $signed({16'd0, cal_offset[63:48]});
  assign ac5 = $signed({16'd0, cal_temp[15:0]});
  assign ac6 = $signed({16'd0, cal_temp[31:16]});
  assign mc  = 32'($signed(cal_temp[47:32]));
  assign md  = 32'($signed(cal_temp[63:48]));
  assign b1  = 32'($signed(cal_curve[15:0]));
  assign b2  = 32'($signed(cal_curve[31:16]));

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Temperature front end.
  logic               a_v, b_v, c_v;
  logic [15:0]        a_ut;
  logic [18:0]        a_up, b_up, c_up;
  logic signed [31:0] b_t1, c_x1, c_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (en) begin
      a_v <= s_axis_tvalid;
      b_v <= a_v;
      c_v <= b_v;
    end
    if (en) begin
      a_ut <= s_axis_tdata[15:0];
      a_up <= s_axis_tdata[34:16];
      b_t1 <= bpc_pkg::mul32($signed({16'd0, a_ut}) - ac6, ac5);
      b_up <= a_up;
      c_x1 <= bpc_pkg::sdiv_p2(b_t1, 5'd15);
      c_dv <= bpc_pkg::sdiv_p2(b_t1, 5'd15) + md;
      c_up <= b_up;
    end
  end

  // Temperature division: (mc * 2048) / (x1 + md), signed via magnitudes.
  logic signed [31:0] mc_sh;
  logic [DIV_W-1:0]   d1_num, d1_den, d1_q;
  logic               d1_neg, d1_err;
  logic [52:0]        d1_side_in, d1_side_out;
  logic               d1_v;

  always_comb begin
    mc_sh      = mc <<< 11;
    d1_neg     = mc_sh[31] ^ c_dv[31];
    d1_err     = c_dv == 32'sd0;
    d1_num     = DIV_W'(mc_sh[31] ? -mc_sh : mc_sh);
    d1_den     = DIV_W'(c_dv[31] ? -c_dv : c_dv);
    d1_side_in = {d1_neg, d1_err, c_up, c_x1};
  end

  bpc_div #(.W(DIV_W), .SIDE_W(53)) u_div_temp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_v),
    .dividend (d1_num),
    .divisor  (d1_den),
    .side_in  (d1_side_in),
    .out_valid(d1_v),
    .quotient (d1_q),
    .side_out (d1_side_out)
  );

  // Pressure coefficient stages.
  logic               d_v, e_v, f_v, g_v, h_v, i_v, j_v;
  logic               d_err, e_err, f_err, g_err, h_err, i_err, j_err;
  logic [18:0]        d_up, e_up, f_up, g_up, h_up, i_up;
  logic signed [31:0] d_b6, e_sqp, e_p1, e_p2, f_sq, f_x2a, f_x1b;
  logic signed [31:0] g_m1, g_m2, g_x2a, g_x1b, h_b3pre, h_x3b;
  logic signed [31:0] i_b3, i_b4m;
  logic [31:0]        j_b4, j_b7;
  logic signed [31:0] x2_t, b5, x3_h, x3b_sum, b3_sum, b7_diff;

  always_comb begin
    x2_t    = d1_side_out[52] ? -$signed(d1_q) : $signed(d1_q);
    b5      = $signed(d1_side_out[31:0]) + x2_t;
    x3_h    = bpc_pkg::sdiv_p2(g_m1, 5'd11) + g_x2a;
    x3b_sum = g_x1b + bpc_pkg::sdiv_p2(g_m2, 5'd16) + 32'sd2;
    b3_sum  = h_b3pre + 32'sd2;
    b7_diff = $signed({13'd0, i_up}) - i_b3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
    end else if (en) begin
      d_v <= d1_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
      j_v <= i_v;
    end
    if (en) begin
      d_b6    <= b5 - bpc_pkg::B6_OFFSET;
      d_up    <= d1_side_out[50:32];
      d_err   <= d1_side_out[51];
      e_sqp   <= bpc_pkg::mul32(d_b6, d_b6);
      e_p1    <= bpc_pkg::mul32(ac2, d_b6);
      e_p2    <= bpc_pkg::mul32(ac3, d_b6);
      e_up    <= d_up;
      e_err   <= d_err;
      f_sq    <= bpc_pkg::sdiv_p2(e_sqp, 5'd12);
      f_x2a   <= bpc_pkg::sdiv_p2(e_p1, 5'd11);
      f_x1b   <= bpc_pkg::sdiv_p2(e_p2, 5'd13);
      f_up    <= e_up;
      f_err   <= e_err;
      g_m1    <= bpc_pkg::mul32(b2, f_sq);
      g_m2    <= bpc_pkg::mul32(b1, f_sq);
      g_x2a   <= f_x2a;
      g_x1b   <= f_x1b;
      g_up    <= f_up;
      g_err   <= f_err;
      h_b3pre <= ((ac1 <<< 2) + x3_h) <<< oss;
      h_x3b   <= bpc_pkg::sdiv_p2(x3b_sum, 5'd2);
      h_up    <= g_up;
      h_err   <= g_err;
      i_b3    <= bpc_pkg::sdiv_p2(b3_sum, 5'd2);
      i_b4m   <= bpc_pkg::mul32(ac4, h_x3b + bpc_pkg::B4_BIAS);
      i_up    <= h_up;
      i_err   <= h_err;
      j_b4    <= 32'(i_b4m) >> 15;
      j_b7    <= 32'(bpc_pkg::mul32(b7_diff, $signed(bpc_pkg::B7_SCALE >> oss)));
      j_err   <= i_err;
    end
  end

  // Pressure division: unsigned, with the doubling placed to avoid overflow.
  logic [DIV_W-1:0] d2_num, d2_den, d2_q;
  logic [1:0]       d2_side_in, d2_side_out;
  logic             d2_v;

  always_comb begin
    d2_num     = DIV_W'(j_b7[31] ? j_b7 : (j_b7 << 1));
    d2_den     = DIV_W'(j_b4);
    d2_side_in = {j_b7[31], j_err || (j_b4 == 32'd0)};
  end

  bpc_div #(.W(DIV_W), .SIDE_W(2)) u_div_press (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (j_v),
    .dividend (d2_num),
    .divisor  (d2_den),
    .side_in  (d2_side_in),
    .out_valid(d2_v),
    .quotient (d2_q),
    .side_out (d2_side_out)
  );

  // Final correction stages.
  logic               k_v, l_v, mm_v;
  logic               k_err, l_err, mm_err;
  logic signed [31:0] k_p, l_p, l_sq2, l_m3, mm_p, mm_m4, mm_m3;
  logic signed [31:0] k_d, fin_sum, fin_p;

  always_comb begin
    k_d     = bpc_pkg::sdiv_p2(k_p, 5'd8);
    fin_sum = bpc_pkg::sdiv_p2(mm_m4, 5'd16) + bpc_pkg::sdiv_p2(mm_m3, 5'd16)
              + bpc_pkg::P_OFFSET;
    fin_p   = mm_p + bpc_pkg::sdiv_p2(fin_sum, 5'd4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v           <= 1'b0;
      l_v           <= 1'b0;
      mm_v          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      k_v           <= d2_v;
      l_v           <= k_v;
      mm_v          <= l_v;
      m_axis_tvalid <= mm_v;
    end
    if (en) begin
      k_p          <= $signed(32'(d2_side_out[1] ? (d2_q << 1) : d2_q));
      k_err        <= d2_side_out[0];
      l_sq2        <= bpc_pkg::mul32(k_d, k_d);
      l_m3         <= bpc_pkg::mul32(bpc_pkg::P_LIN_COEF, k_p);
      l_p          <= k_p;
      l_err        <= k_err;
      mm_m4        <= bpc_pkg::mul32(l_sq2, bpc_pkg::P_SQ_COEF);
      mm_m3        <= l_m3;
      mm_p         <= l_p;
      mm_err       <= l_err;
      m_axis_tdata <= mm_err ? '0 : DIV_W'(fin_p);
      m_axis_tuser <= mm_err;
    end
  end

endmodule
`default_nettype wire

// File: verif/tb.sv
// Testbench for barometric_pressure_compensation_core: directed table, then random readings.
// Predicts results by integer model or table row; depends on bpc_pkg and the core RTL.
`timescale 1ns / 100ps
module tb;

  localparam int HALF_PERIOD = 5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_ITEMS = 1530;

  typedef struct packed {
    logic [31:0] pressure;
    logic        div_err;
  } comp_result_t;

  typedef struct {
    logic [15:0] ut;
    logic [18:0] up;
    bit          known;
    comp_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] offset_terms, temp_terms;
  logic [31:0] curve_terms;
  logic [1:0]  oss_mode;

  comp_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int div_errors_seen = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stall_enable = 1'b0;

  barometric_pressure_compensation_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic signed [31:0] tdiv(logic signed [31:0] a, logic signed [31:0] b);
    if (a == 32'sh8000_0000 && b == -32'sd1) begin
      return a;
    end
    return a / b;
  endfunction

  function automatic comp_result_t compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
    logic signed [31:0] ac1, ac2, ac3, ac5, ac6, mc, md, b1, b2;
    logic signed [31:0] ut, x1, x2, x3, b3, b5, b6, sq, dv, p;
    logic [31:0] ac4, up, b4, b7, pu;
    comp_result_t r;
    ac1 = 32'($signed(offset_terms[15:0]));
    ac2 = 32'($signed(offset_terms[31:16]));
    ac3 = 32'($signed(offset_terms[47:32]));
    ac4 = {16'd0, offset_terms[63:48]};
    ac5 = {16'd0, temp_terms[15:0]};
    ac6 = {16'd0, temp_terms[31:16]};
    mc = 32'($signed(temp_terms[47:32]));
    md = 32'($signed(temp_terms[63:48]));
    b1 = 32'($signed(curve_terms[15:0]));
    b2 = 32'($signed(curve_terms[31:16]));
    ut = {16'd0, ut_raw};
    up = {13'd0, up_raw};
    r = '{pressure: 32'd0, div_err: 1'b1};
    x1 = tdiv((ut - ac6) * ac5, 32768);
    dv = x1 + md;
    if (dv == 0) begin
      return r;
    end
    x2 = tdiv(mc * 2048, dv);
    b5 = x1 + x2;
    b6 = b5 - 4000;
    sq = tdiv(b6 * b6, 4096);
    x1 = tdiv(b2 * sq, 2048);
    x2 = tdiv(ac2 * b6, 2048);
    x3 = x1 + x2;
    b3 = (ac1 * 4 + x3) << oss_mode;
    b3 = tdiv(b3 + 2, 4);
    x1 = tdiv(ac3 * b6, 8192);
    x2 = tdiv(b1 * sq, 65536);
    x3 = tdiv(x1 + x2 + 2, 4);
    b4 = (ac4 * (x3 + 32'd32768)) / 32'd32768;
    b7 = (up - b3) * (32'd50000 >> oss_mode);
    if (b4 == 0) begin
      return r;
    end
    if (b7 < 32'h8000_0000) begin
      pu = (b7 * 2) / b4;
    end else begin
      pu = (b7 / b4) * 2;
    end
    p = pu;
    x1 = tdiv(p, 256) * tdiv(p, 256);
    x1 = tdiv(x1 * 3038, 65536);
    x2 = tdiv(-32'sd7357 * p, 65536);
    p = p + tdiv(x1 + x2 + 3791, 16);
    r = '{pressure: p, div_err: 1'b0};
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bpc_pkg::REG_OFFSET:      offset_terms = value;
      bpc_pkg::REG_TEMPERATURE: temp_terms = value;
      bpc_pkg::REG_CURVATURE:   curve_terms = value[31:0];
      bpc_pkg::REG_OVERSAMPLE:  oss_mode = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_calibration(logic [63:0] off, logic [63:0] tmp, logic [31:0] crv,
                                 logic [1:0] oss);
    write_reg(bpc_pkg::REG_OFFSET, off);
    write_reg(bpc_pkg::REG_TEMPERATURE, tmp);
    write_reg(bpc_pkg::REG_CURVATURE, {32'd0, crv});
    write_reg(bpc_pkg::REG_OVERSAMPLE, {62'd0, oss});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sends one reading; the expected value is queued when the transfer completes.
  task automatic send_reading(logic [15:0] ut, logic [18:0] up, bit known, comp_result_t res);
    comp_result_t exp_res;
    exp_res = known ? res : compensate(ut, up);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, up, ut};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(exp_res);
  endtask

  task automatic gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Calibration close to a real sensor.
  localparam logic [63:0] TYP_OFFSET = {16'd32741, 16'hC7A9, 16'hFBA5, 16'd408};
  localparam logic [63:0] TYP_TEMP   = {16'd2868, 16'hD4BD, 16'd23153, 16'd32757};
  localparam logic [31:0] TYP_CURVE  = {16'd4, 16'd6190};

  task automatic run_random(int count);
    int burst;
    for (int i = 0; i < count; i = i + burst) begin
      burst = $urandom_range(1, 40);
      if (burst > count - i) begin
        burst = count - i;
      end
      for (int j = 0; j < burst; j++) begin
        case ($urandom_range(0, 3))
          0: send_reading(16'($urandom), 19'($urandom), 1'b0, '0);
          1: send_reading(16'($urandom_range(20000, 32000)),
                          19'($urandom_range(20000, 100000) << oss_mode), 1'b0, '0);
          2: send_reading({$urandom_range(0,1) ? 16'hFFFF : 16'h0000}, 19'($urandom),
                          1'b0, '0);
          default: send_reading(16'($urandom_range(27000, 28000)), 19'($urandom), 1'b0, '0);
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        gap($urandom_range(1, 12));
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %h/%b", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        comp_result_t e;
        e = pending_results.pop_front();
        results_seen++;
        if (m_axis_tuser) div_errors_seen++;
        if (m_axis_tdata !== e.pressure) begin
          $display("%0t: pressure_pa expected %0d actual %0d", $time, $signed(e.pressure),
                   $signed(m_axis_tdata));
          errors++;
        end
        if (m_axis_tuser !== e.div_err) begin
          $display("%0t: divide_error expected %b actual %b", $time, e.div_err, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (stall_enable) begin
      m_axis_tready <= ($urandom_range(0, 9) < 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  stim_row_t table_rows[$];

  initial begin
    offset_terms = '0;
    temp_terms = '0;
    curve_terms = '0;
    oss_mode = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset every coefficient is zero: x1 + md is zero, so the divide flag is set.
    send_reading(16'd0, 19'd0, 1'b1, '{pressure: 32'd0, div_err: 1'b1});
    send_reading(16'hFFFF, 19'h7FFFF, 1'b1, '{pressure: 32'd0, div_err: 1'b1});
    gap(1);
    wait_drained();

    // md nonzero but ac4 zero: the pressure divisor b4 is zero.
    set_calibration(64'h0000_1234_5678_9ABC, 64'h0001_0000_0000_0000, 32'd0, 2'd0);
    table_rows = {};
    table_rows.push_back('{16'd1000, 19'd5, 1'b1, '{32'd0, 1'b1}});
    table_rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b1, '{32'd0, 1'b1}});
    foreach (table_rows[k]) send_reading(table_rows[k].ut, table_rows[k].up,
                                         table_rows[k].known, table_rows[k].res);
    gap(1);
    wait_drained();

    // Typical calibration and extremes of every field, each oversampling setting.
    for (int o = 0; o < 4; o++) begin
      set_calibration(TYP_OFFSET, TYP_TEMP, TYP_CURVE, o[1:0]);
      table_rows = {};
      table_rows.push_back('{16'd27898, 19'd23843 << o, 1'b0, '0});
      table_rows.push_back('{16'd0, 19'd0, 1'b0, '0});
      table_rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b0, '0});
      table_rows.push_back('{16'h8000, 19'h40000, 1'b0, '0});
      foreach (table_rows[k]) send_reading(table_rows[k].ut, table_rows[k].up,
                                           table_rows[k].known, table_rows[k].res);
      gap(1);
      wait_drained();
    end

    // Extreme calibration patterns that drive signed overflow.
    set_calibration('1, 64'h8000_7FFF_FFFF_FFFF, 32'h8000_7FFF, 2'd3);
    send_reading(16'hFFFF, 19'h7FFFF, 1'b0, '0);
    send_reading(16'd0, 19'd0, 1'b0, '0);
    send_reading(16'd1, 19'd1, 1'b0, '0);
    gap(1);
    wait_drained();
    set_calibration(64'h8000_8000_8000_8000, 64'h7FFF_8000_0001_0001, 32'h7FFF_8000, 2'd0);
    send_reading(16'h5555, 19'h2AAAA, 1'b0, '0);
    send_reading(16'hAAAA, 19'h55555, 1'b0, '0);
    gap(1);
    wait_drained();

    // Random part with stalls; first a long receiver hold-off so the pipeline fills.
    stall_enable = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0, 1: set_calibration(TYP_OFFSET, TYP_TEMP, TYP_CURVE, phase[1:0]);
        2: set_calibration(TYP_OFFSET ^ {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF,
                           TYP_TEMP, TYP_CURVE, 2'd2);
        3: set_calibration({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 2'd3);
        4: set_calibration({$urandom, $urandom}, {16'd0, $urandom_range(0, 3) == 0 ? 16'd0 :
                           16'($urandom), 32'($urandom)}, $urandom, 2'($urandom));
        default: set_calibration(TYP_OFFSET, {16'($urandom), TYP_TEMP[47:0]}, TYP_CURVE,
                                 2'($urandom));
      endcase
      if (phase == 0) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
          run_random(RANDOM_ITEMS / 6);
        join
      end else begin
        run_random(RANDOM_ITEMS / 6);
      end
      wait_drained();
    end
    stall_enable = 1'b0;

    $display("Covered %0d results (%0d with divide flag) over reset, zero-divisor,", results_seen,
             div_errors_seen);
    $display("extreme and random calibrations in all four oversampling settings.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bpc_pkg.sv
design/bpc_div.sv
design/barometric_pressure_compensation_core.sv
verif/tb.sv
